[rtl/core/pal_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_pkg
// Shared types, codes and item layouts of the positional array list unit.
// ----------------------------------------------------------------------------
package pal_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int WORD_W       = 32;
  localparam int POS_W        = 8;
  localparam int MODE_W       = 3;

  // input item layout, lowest bit first
  localparam int S_MODE_LSB  = 0;
  localparam int S_POS_LSB   = S_MODE_LSB + MODE_W;
  localparam int S_VALUE_LSB = S_POS_LSB + POS_W;
  localparam int S_USED_W    = S_VALUE_LSB + WORD_W;
  localparam int S_TDATA_W   = ((S_USED_W + 7) / 8) * 8;

  // result item layout, lowest bit first
  localparam int M_STATUS_LSB = 0;
  localparam int M_READ_LSB   = M_STATUS_LSB + 2;
  localparam int M_FOUND_LSB  = M_READ_LSB + WORD_W;
  localparam int M_COUNT_LSB  = M_FOUND_LSB + POS_W;
  localparam int M_EMPTY_LSB  = M_COUNT_LSB + POS_W;
  localparam int M_USED_W     = M_EMPTY_LSB + 1;
  localparam int M_TDATA_W    = ((M_USED_W + 7) / 8) * 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 3'd0,
    MODE_DELETE = 3'd1,
    MODE_GET    = 3'd2,
    MODE_LOCATE = 3'd3,
    MODE_CLEAR  = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_BAD  = 2'd2,
    STAT_MISS = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_INS_RD,
    ST_INS_WR,
    ST_DEL_CAP,
    ST_DEL_RD,
    ST_DEL_WR,
    ST_GET_CAP,
    ST_LOC_RD,
    ST_LOC_CMP,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    RD_CUR,
    RD_CUR_M1,
    RD_POS_M1
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_UP,
    WR_DOWN,
    WR_PUT
  } wr_sel_t;

  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_FILL,
    CUR_POS,
    CUR_ZERO,
    CUR_INC,
    CUR_DEC
  } cur_op_t;

  typedef enum logic [1:0] {
    FILL_HOLD,
    FILL_INC,
    FILL_DEC,
    FILL_ZERO
  } fill_op_t;

  typedef struct packed {
    logic     load_req;
    logic     rd_en;
    rd_sel_t  rd_sel;
    logic     wr_en;
    wr_sel_t  wr_sel;
    cur_op_t  cur_op;
    fill_op_t fill_op;
    logic     cap_read;
    logic     set_found;
    logic     set_status;
    status_t  status_code;
    logic     load_out;
  } pal_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              full;
    logic              ins_pos_ok;
    logic              acc_pos_ok;
    logic              cur_ge_pos;
    logic              cur_lt_fill;
    logic              match;
    logic              out_free;
  } pal_sts_t;

  function automatic int addr_bits(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

[rtl/core/pal_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [pal_pkg::addr_bits(DEPTH)-1:0]     wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [pal_pkg::addr_bits(DEPTH)-1:0]     rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/pal_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_datapath
// Request registers, fill and cursor counters, entry RAM and result register.
// ----------------------------------------------------------------------------
module pal_datapath #(
  parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  pal_pkg::pal_cmd_t           cmd,
  output pal_pkg::pal_sts_t           sts,
  input  logic [pal_pkg::MODE_W-1:0]  in_mode,
  input  logic [pal_pkg::POS_W-1:0]   in_position,
  input  logic [pal_pkg::WORD_W-1:0]  in_value,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [1:0]                  out_status,
  output logic [pal_pkg::WORD_W-1:0]  out_read_value,
  output logic [pal_pkg::POS_W-1:0]   out_found_position,
  output logic [pal_pkg::POS_W-1:0]   out_count,
  output logic                        out_is_empty
);

  import pal_pkg::*;

  localparam int AW = addr_bits(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [MODE_W-1:0] req_mode;
  logic [POS_W-1:0]  req_pos;
  logic [WORD_W-1:0] req_val;
  logic [CW-1:0]     fill;
  logic [CW-1:0]     fill_next;
  logic [CW-1:0]     cur;
  logic [CW-1:0]     cur_next;
  logic [WORD_W-1:0] rd_val;
  logic [POS_W-1:0]  found;
  status_t           status;

  logic [POS_W:0]    pos9;
  logic [POS_W:0]    fill9;
  logic [POS_W:0]    cur9;
  logic [AW-1:0]     pos_m1;
  logic [AW-1:0]     cur_m1;
  logic [AW-1:0]     cur_a;

  logic              ram_wr_en;
  logic [AW-1:0]     ram_wr_addr;
  logic [WORD_W-1:0] ram_wr_data;
  logic [AW-1:0]     ram_rd_addr;
  logic [WORD_W-1:0] ram_rd_data;

  assign pos9   = {1'b0, req_pos};
  assign fill9  = (POS_W + 1)'(fill);
  assign cur9   = (POS_W + 1)'(cur);
  assign pos_m1 = AW'(pos9 - 9'd1);
  assign cur_m1 = AW'(cur9 - 9'd1);
  assign cur_a  = AW'(cur9);

  assign sts.mode        = req_mode;
  assign sts.full        = (fill9 >= (POS_W + 1)'(CAPACITY));
  assign sts.ins_pos_ok  = (req_pos != '0) && (pos9 <= fill9 + 9'd1);
  assign sts.acc_pos_ok  = (req_pos != '0) && (pos9 <= fill9);
  assign sts.cur_ge_pos  = (cur9 >= pos9);
  assign sts.cur_lt_fill = (cur < fill);
  assign sts.match       = (ram_rd_data == req_val);
  assign sts.out_free    = !out_valid || out_ready;

  // ram port selection
  always_comb begin
    ram_wr_en = cmd.wr_en;
    case (cmd.rd_sel)
      RD_CUR:    ram_rd_addr = cur_a;
      RD_CUR_M1: ram_rd_addr = cur_m1;
      RD_POS_M1: ram_rd_addr = pos_m1;
      default:   ram_rd_addr = cur_a;
    endcase
    case (cmd.wr_sel)
      WR_UP: begin
        ram_wr_addr = cur_a;
        ram_wr_data = ram_rd_data;
      end
      WR_DOWN: begin
        ram_wr_addr = cur_m1;
        ram_wr_data = ram_rd_data;
      end
      WR_PUT: begin
        ram_wr_addr = pos_m1;
        ram_wr_data = req_val;
      end
      default: begin
        ram_wr_addr = cur_a;
        ram_wr_data = ram_rd_data;
      end
    endcase
  end

  pal_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    case (cmd.cur_op)
      CUR_HOLD: cur_next = cur;
      CUR_FILL: cur_next = fill;
      CUR_POS:  cur_next = CW'(pos9);
      CUR_ZERO: cur_next = '0;
      CUR_INC:  cur_next = cur + CW'(1);
      CUR_DEC:  cur_next = cur - CW'(1);
      default:  cur_next = cur;
    endcase
    case (cmd.fill_op)
      FILL_HOLD: fill_next = fill;
      FILL_INC:  fill_next = fill + CW'(1);
      FILL_DEC:  fill_next = fill - CW'(1);
      FILL_ZERO: fill_next = '0;
      default:   fill_next = fill;
    endcase
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    if (cmd.load_req) begin
      req_mode <= in_mode;
      req_pos  <= in_position;
      req_val  <= in_value;
      rd_val   <= '0;
      found    <= '0;
      status   <= STAT_OK;
    end else begin
      if (cmd.cap_read) begin
        rd_val <= ram_rd_data;
      end
      if (cmd.set_found) begin
        found  <= POS_W'(cur9 + 9'd1);
        status <= STAT_OK;
      end
      if (cmd.set_status) begin
        status <= cmd.status_code;
      end
    end
    if (cmd.load_out) begin
      out_status         <= status;
      out_read_value     <= rd_val;
      out_found_position <= found;
      out_count          <= POS_W'(fill);
      out_is_empty       <= (fill == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      fill <= fill_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/core/pal_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_ctrl
// Sequencer that steps each request through reads, shifts and the result.
// ----------------------------------------------------------------------------
module pal_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  pal_pkg::pal_sts_t sts,
  output pal_pkg::pal_cmd_t cmd
);

  import pal_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (sts.mode)
          MODE_INSERT: begin
            state_next = (sts.full || !sts.ins_pos_ok) ? ST_FINISH : ST_INS_RD;
          end
          MODE_DELETE: state_next = sts.acc_pos_ok ? ST_DEL_CAP : ST_FINISH;
          MODE_GET:    state_next = sts.acc_pos_ok ? ST_GET_CAP : ST_FINISH;
          MODE_LOCATE: state_next = ST_LOC_RD;
          default:     state_next = ST_FINISH;
        endcase
      end
      ST_INS_RD:  state_next = sts.cur_ge_pos ? ST_INS_WR : ST_FINISH;
      ST_INS_WR:  state_next = ST_INS_RD;
      ST_DEL_CAP: state_next = ST_DEL_RD;
      ST_DEL_RD:  state_next = sts.cur_lt_fill ? ST_DEL_WR : ST_FINISH;
      ST_DEL_WR:  state_next = ST_DEL_RD;
      ST_GET_CAP: state_next = ST_FINISH;
      ST_LOC_RD:  state_next = sts.cur_lt_fill ? ST_LOC_CMP : ST_FINISH;
      ST_LOC_CMP: state_next = sts.match ? ST_FINISH : ST_LOC_RD;
      ST_FINISH: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    in_ready        = 1'b0;
    cmd             = '0;
    cmd.rd_sel      = RD_CUR;
    cmd.wr_sel      = WR_UP;
    cmd.cur_op      = CUR_HOLD;
    cmd.fill_op     = FILL_HOLD;
    cmd.status_code = STAT_OK;
    case (state)
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.load_req = in_valid;
      end
      ST_DECODE: begin
        case (sts.mode)
          MODE_INSERT: begin
            if (sts.full) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = STAT_FULL;
            end else if (!sts.ins_pos_ok) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = STAT_BAD;
            end else begin
              cmd.cur_op = CUR_FILL;
            end
          end
          MODE_DELETE, MODE_GET: begin
            if (sts.acc_pos_ok) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_POS_M1;
            end else begin
              cmd.set_status  = 1'b1;
              cmd.status_code = STAT_BAD;
            end
          end
          MODE_LOCATE: cmd.cur_op = CUR_ZERO;
          MODE_CLEAR:  cmd.fill_op = FILL_ZERO;
          default: begin
            cmd.set_status  = 1'b1;
            cmd.status_code = STAT_BAD;
          end
        endcase
      end
      ST_INS_RD: begin
        if (sts.cur_ge_pos) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_CUR_M1;
        end else begin
          cmd.wr_en   = 1'b1;
          cmd.wr_sel  = WR_PUT;
          cmd.fill_op = FILL_INC;
        end
      end
      ST_INS_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_UP;
        cmd.cur_op = CUR_DEC;
      end
      ST_DEL_CAP: begin
        cmd.cap_read = 1'b1;
        cmd.cur_op   = CUR_POS;
      end
      ST_DEL_RD: begin
        if (sts.cur_lt_fill) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_CUR;
        end else begin
          cmd.fill_op = FILL_DEC;
        end
      end
      ST_DEL_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_DOWN;
        cmd.cur_op = CUR_INC;
      end
      ST_GET_CAP: cmd.cap_read = 1'b1;
      ST_LOC_RD: begin
        if (sts.cur_lt_fill) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_CUR;
        end else begin
          cmd.set_status  = 1'b1;
          cmd.status_code = STAT_MISS;
        end
      end
      ST_LOC_CMP: begin
        if (sts.match) begin
          cmd.set_found = 1'b1;
        end else begin
          cmd.cur_op = CUR_INC;
        end
      end
      ST_FINISH: cmd.load_out = sts.out_free;
      default: ;
    endcase
  end

endmodule

[rtl/core/positional_array_list_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_array_list_unit
// Bounded ordered list of signed words addressed by 1-based position.
// ----------------------------------------------------------------------------
// Requests enter on the s_ stream (mode, position, value); one result item
// per request leaves on the m_ stream (status, read value, found position,
// count, empty flag). The entries sit in a single-port-read, single-port-write
// RAM, so shifting and searching walk it one entry at a time, with a read
// step and then a write-back or compare step for each entry.
// Insert shifts the entries from the position to the count up by one,
// delete shifts the entries above the position down, get reads one entry,
// locate compares from position 1 until a hit or the end of the list, and
// clear and rejected requests go straight to the result.
// One request is worked on at a time; s_tready is high only between requests,
// so the next request can be taken in the cycle after the result is loaded.
// A finished result waits in the output register while the next request is
// taken; if m_tready stays low the sequencer holds its final step until the
// register frees. Reset empties the list and drops any pending result; the
// RAM contents are not cleared, only entries below the count are ever read.
// ----------------------------------------------------------------------------
module positional_array_list_unit #(
  parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [pal_pkg::S_TDATA_W-1:0] s_tdata,  // mode, position, value
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [pal_pkg::M_TDATA_W-1:0] m_tdata   // status, read_value,
                                                  // found_position, count,
                                                  // is_empty
);

  import pal_pkg::*;

  pal_cmd_t          cmd;
  pal_sts_t          sts;
  logic [1:0]        out_status;
  logic [WORD_W-1:0] out_read_value;
  logic [POS_W-1:0]  out_found_position;
  logic [POS_W-1:0]  out_count;
  logic              out_is_empty;

  pal_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pal_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .sts                (sts),
    .in_mode            (s_tdata[S_MODE_LSB +: MODE_W]),
    .in_position        (s_tdata[S_POS_LSB +: POS_W]),
    .in_value           (s_tdata[S_VALUE_LSB +: WORD_W]),
    .out_ready          (m_tready),
    .out_valid          (m_tvalid),
    .out_status         (out_status),
    .out_read_value     (out_read_value),
    .out_found_position (out_found_position),
    .out_count          (out_count),
    .out_is_empty       (out_is_empty)
  );

  assign m_tdata = {{(M_TDATA_W - M_USED_W){1'b0}}, out_is_empty, out_count,
                    out_found_position, out_read_value, out_status};

endmodule

[rtl/core/pal_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_checker
// Port-level assertions for the positional array list unit, bound to the top.
// ----------------------------------------------------------------------------
module pal_checker #(
  parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [pal_pkg::S_TDATA_W-1:0] s_tdata,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [pal_pkg::M_TDATA_W-1:0] m_tdata
);

  import pal_pkg::*;

  logic [1:0]       chk_status;
  logic [POS_W-1:0] chk_count;
  logic             chk_empty;
  logic             chk_in_fire;

  assign chk_status  = m_tdata[M_STATUS_LSB +: 2];
  assign chk_count   = m_tdata[M_COUNT_LSB +: POS_W];
  assign chk_empty   = m_tdata[M_EMPTY_LSB];
  assign chk_in_fire = s_tvalid && s_tready && (s_tdata != '1);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result pending after reset");

  a_out_held: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (chk_empty == (chk_count == '0)))
    else $error("empty flag disagrees with count");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (chk_status == STAT_FULL) |-> (chk_count == POS_W'(CAPACITY)))
    else $error("full reported below capacity");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    chk_in_fire |=> !s_tready)
    else $error("second item taken while busy");

endmodule

bind positional_array_list_unit pal_checker #(
  .CAPACITY (CAPACITY)
) u_pal_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
